// ===== design/midx_pkg.sv =====
// ----------------------------------------------------------------------------
// midx_pkg
// Shared types, codes, key packing and the control program of the
// message ID index lookup.
// ----------------------------------------------------------------------------
package midx_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;

  localparam logic [15:0] NOT_FOUND_IDX = 16'hFFFF;
  localparam logic [31:0] ALL_ONES_KEY  = 32'hFFFF_FFFF;

  localparam logic [7:0] REG_TABLE_PRESENT = 8'd0;
  localparam logic [7:0] REG_KEY_FORMAT    = 8'd1;
  localparam logic [7:0] REG_SORTED_TABLE  = 8'd2;
  localparam logic [7:0] REG_ENTRY_COUNT   = 8'd3;

  localparam logic [2:0] FMT_ID    = 3'd0;
  localparam logic [2:0] FMT_ID24  = 3'd1;
  localparam logic [2:0] FMT_ID16  = 3'd2;
  localparam logic [2:0] FMT_ID8   = 3'd3;
  localparam logic [2:0] FMT_UPPER = 3'd4;

  typedef enum logic [1:0] {
    ST_FOUND,
    ST_MISS,
    ST_NO_TABLE,
    ST_BAD_FMT
  } status_t;

  typedef enum logic [3:0] {
    STEP_IDLE,
    STEP_PACK,
    STEP_DISPATCH,
    STEP_LSCAN,
    STEP_BTEST,
    STEP_BCMP,
    STEP_BFIN,
    STEP_BCHK,
    STEP_OUT
  } step_t;

  typedef enum logic [3:0] {
    OP_WAIT,
    OP_PACK,
    OP_NOP,
    OP_LSCAN,
    OP_BTEST,
    OP_BCMP,
    OP_BFIN,
    OP_BCHK,
    OP_SEND
  } op_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_ACC_LOOKUP,
    C_EARLY,
    C_SORTED,
    C_SCAN_DONE,
    C_LEN_ZERO,
    C_FIRST_GE,
    C_OUT_TAKEN
  } cond_t;

  typedef struct packed {
    logic  in_ready;
    logic  out_valid;
    op_t   op;
    cond_t cond;
    step_t jmp;
    step_t nxt;
  } ctrl_word_t;

  typedef struct packed {
    logic acc_lookup;
    logic early;
    logic sorted;
    logic scan_done;
    logic len_zero;
    logic first_ge;
    logic out_taken;
  } cond_flags_t;

  typedef struct packed {
    logic [31:0] key;
    logic        fits;
    logic        known;
  } pack_res_t;

  function automatic ctrl_word_t ucode_rom(step_t s);
    ctrl_word_t w;
    w = '{in_ready: 1'b1, out_valid: 1'b0, op: OP_WAIT, cond: C_ACC_LOOKUP,
          jmp: STEP_PACK, nxt: STEP_IDLE};
    case (s)
      STEP_IDLE: begin
        w = '{in_ready: 1'b1, out_valid: 1'b0, op: OP_WAIT, cond: C_ACC_LOOKUP,
              jmp: STEP_PACK, nxt: STEP_IDLE};
      end
      STEP_PACK: begin
        w = '{in_ready: 1'b0, out_valid: 1'b0, op: OP_PACK, cond: C_EARLY,
              jmp: STEP_OUT, nxt: STEP_DISPATCH};
      end
      STEP_DISPATCH: begin
        w = '{in_ready: 1'b0, out_valid: 1'b0, op: OP_NOP, cond: C_SORTED,
              jmp: STEP_BTEST, nxt: STEP_LSCAN};
      end
      STEP_LSCAN: begin
        w = '{in_ready: 1'b0, out_valid: 1'b0, op: OP_LSCAN, cond: C_SCAN_DONE,
              jmp: STEP_OUT, nxt: STEP_LSCAN};
      end
      STEP_BTEST: begin
        w = '{in_ready: 1'b0, out_valid: 1'b0, op: OP_BTEST, cond: C_LEN_ZERO,
              jmp: STEP_BFIN, nxt: STEP_BCMP};
      end
      STEP_BCMP: begin
        w = '{in_ready: 1'b0, out_valid: 1'b0, op: OP_BCMP, cond: C_ALWAYS,
              jmp: STEP_BTEST, nxt: STEP_BTEST};
      end
      STEP_BFIN: begin
        w = '{in_ready: 1'b0, out_valid: 1'b0, op: OP_BFIN, cond: C_FIRST_GE,
              jmp: STEP_OUT, nxt: STEP_BCHK};
      end
      STEP_BCHK: begin
        w = '{in_ready: 1'b0, out_valid: 1'b0, op: OP_BCHK, cond: C_ALWAYS,
              jmp: STEP_OUT, nxt: STEP_OUT};
      end
      STEP_OUT: begin
        w = '{in_ready: 1'b0, out_valid: 1'b1, op: OP_SEND, cond: C_OUT_TAKEN,
              jmp: STEP_IDLE, nxt: STEP_OUT};
      end
      default: begin
        w = '{in_ready: 1'b1, out_valid: 1'b0, op: OP_WAIT, cond: C_ACC_LOOKUP,
              jmp: STEP_PACK, nxt: STEP_IDLE};
      end
    endcase
    return w;
  endfunction

  function automatic pack_res_t pack_key(logic [31:0] id, logic [31:0] up,
                                         logic [2:0] fmt);
    pack_res_t r;
    r.key   = id;
    r.fits  = 1'b0;
    r.known = 1'b1;
    case (fmt)
      FMT_ID: begin
        r.key  = id;
        r.fits = (up == 32'd0);
      end
      FMT_ID24: begin
        r.key  = {id[23:0], up[7:0]};
        r.fits = (id[31:24] == 8'd0) && (up[31:8] == 24'd0);
      end
      FMT_ID16: begin
        r.key  = {id[15:0], up[15:0]};
        r.fits = (id[31:16] == 16'd0) && (up[31:16] == 16'd0);
      end
      FMT_ID8: begin
        r.key  = {id[7:0], up[23:0]};
        r.fits = (id[31:8] == 24'd0) && (up[31:24] == 8'd0);
      end
      FMT_UPPER: begin
        r.key  = up;
        r.fits = (id == 32'd0);
      end
      default: begin
        r.known = 1'b0;
      end
    endcase
    return r;
  endfunction

endpackage

// ===== design/midx_ram.sv =====
// ----------------------------------------------------------------------------
// midx_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module midx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/midx_seq.sv =====
// ----------------------------------------------------------------------------
// midx_seq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
module midx_seq
  import midx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cond_flags_t flags,
  output ctrl_word_t  ctrl
);

  step_t step_r;
  step_t step_nxt;
  logic  take;

  always_comb begin
    ctrl = ucode_rom(step_r);
  end

  always_comb begin
    case (ctrl.cond)
      C_ALWAYS:     take = 1'b1;
      C_ACC_LOOKUP: take = flags.acc_lookup;
      C_EARLY:      take = flags.early;
      C_SORTED:     take = flags.sorted;
      C_SCAN_DONE:  take = flags.scan_done;
      C_LEN_ZERO:   take = flags.len_zero;
      C_FIRST_GE:   take = flags.first_ge;
      C_OUT_TAKEN:  take = flags.out_taken;
      default:      take = 1'b1;
    endcase
    step_nxt = take ? ctrl.jmp : ctrl.nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ===== design/message_id_index_lookup.sv =====
// ----------------------------------------------------------------------------
// message_id_index_lookup
// Maps a packed message key to its index in a table of 32-bit IDs.
// ----------------------------------------------------------------------------
// A load request (mode 0) writes one table entry when it is accepted. A
// lookup request (mode 1) is handled one at a time under control of a small
// microcode program: a PACK step packs the key, a DISPATCH step picks the
// search, then the search runs through the table RAM, whose single read
// port reads one entry per cycle. The entry_count is taken as at most
// TABLE_DEPTH; a binary search runs a BTEST and a BCMP step per halving.
// No table, unknown format, the all-ones key and a zero entry_count answer
// straight from the PACK step, with no search. The result is held until it
// is taken, and the next request is accepted in the cycle after that.
module message_id_index_lookup
  import midx_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_addr,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [9:0]  in_entry_addr,
  input  logic [31:0] in_entry_value,
  input  logic [31:0] in_msg_id,
  input  logic [31:0] in_upper_half,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_index,
  output logic        out_key_valid,
  output logic [1:0]  out_status
);

  localparam int AW = $clog2(TABLE_DEPTH > 1 ? TABLE_DEPTH : 2);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  ctrl_word_t  ctrl;
  cond_flags_t flags;

  logic        tbl_present_r;
  logic [2:0]  key_fmt_r;
  logic        sorted_r;
  logic [10:0] entry_cnt_r;

  logic [31:0] id_r, id_nxt;
  logic [31:0] up_r, up_nxt;
  logic [31:0] key_r, key_nxt;
  logic        kv_r, kv_nxt;
  status_t     status_r, status_nxt;
  logic [15:0] index_r, index_nxt;
  logic [CW-1:0] first_r, first_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic [CW-1:0] mid_r, mid_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic          pend_r, pend_nxt;

  logic [31:0]   used_w;
  logic [CW-1:0] used;
  logic [CW-1:0] half;
  logic [CW-1:0] mid;
  pack_res_t     pk;
  logic          hit_l;
  logic          in_acc;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  midx_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  midx_ram #(
    .WIDTH (32),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_entry_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_present_r <= 1'b0;
      key_fmt_r     <= 3'd0;
      sorted_r      <= 1'b0;
      entry_cnt_r   <= 11'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        REG_TABLE_PRESENT: tbl_present_r <= cfg_data[0];
        REG_KEY_FORMAT:    key_fmt_r     <= cfg_data[2:0];
        REG_SORTED_TABLE:  sorted_r      <= cfg_data[0];
        REG_ENTRY_COUNT:   entry_cnt_r   <= cfg_data[10:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ready      = ctrl.in_ready;
  assign out_valid     = ctrl.out_valid;
  assign out_index     = index_r;
  assign out_key_valid = kv_r;
  assign out_status    = status_r;

  assign in_acc    = in_valid && in_ready;
  assign ram_we    = in_acc && !in_mode && (32'(in_entry_addr) < 32'(TABLE_DEPTH));
  assign ram_waddr = AW'(in_entry_addr);

  always_comb begin
    used_w = (32'(entry_cnt_r) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH)
                                                   : 32'(entry_cnt_r);
    used   = CW'(used_w);
    half   = len_r >> 1;
    mid    = first_r + half;
    pk     = pack_key(id_r, up_r, key_fmt_r);
    hit_l  = pend_r && (ram_rdata == key_r);
  end

  always_comb begin
    case (ctrl.op)
      OP_LSCAN: ram_raddr = i_r[AW-1:0];
      OP_BTEST: ram_raddr = mid[AW-1:0];
      default:  ram_raddr = first_r[AW-1:0];
    endcase
  end

  always_comb begin
    flags.acc_lookup = in_acc && in_mode;
    flags.early      = !tbl_present_r || !pk.known || (pk.key == ALL_ONES_KEY) ||
                       (used == '0);
    flags.sorted     = sorted_r;
    flags.scan_done  = hit_l || (i_r == used);
    flags.len_zero   = (len_r == '0);
    flags.first_ge   = (first_r >= used);
    flags.out_taken  = out_ready;
  end

  always_comb begin
    id_nxt     = id_r;
    up_nxt     = up_r;
    key_nxt    = key_r;
    kv_nxt     = kv_r;
    status_nxt = status_r;
    index_nxt  = index_r;
    first_nxt  = first_r;
    len_nxt    = len_r;
    mid_nxt    = mid_r;
    i_nxt      = i_r;
    pos_nxt    = pos_r;
    pend_nxt   = pend_r;
    case (ctrl.op)
      OP_WAIT: begin
        if (in_acc && in_mode) begin
          id_nxt = in_msg_id;
          up_nxt = in_upper_half;
        end
      end
      OP_PACK: begin
        key_nxt   = pk.key;
        kv_nxt    = tbl_present_r && pk.known && pk.fits;
        index_nxt = NOT_FOUND_IDX;
        if (!tbl_present_r) begin
          status_nxt = ST_NO_TABLE;
        end else if (!pk.known) begin
          status_nxt = ST_BAD_FMT;
        end else begin
          status_nxt = ST_MISS;
        end
        first_nxt = '0;
        len_nxt   = used;
        i_nxt     = '0;
        pend_nxt  = 1'b0;
      end
      OP_LSCAN: begin
        if (hit_l) begin
          status_nxt = ST_FOUND;
          index_nxt  = 16'(pos_r);
        end else if (i_r != used) begin
          pos_nxt  = i_r;
          pend_nxt = 1'b1;
          i_nxt    = i_r + CW'(1);
        end
      end
      OP_BTEST: begin
        mid_nxt = mid;
      end
      OP_BCMP: begin
        if (ram_rdata < key_r) begin
          first_nxt = mid_r + CW'(1);
          len_nxt   = len_r - half - CW'(1);
        end else begin
          len_nxt = half;
        end
      end
      OP_BCHK: begin
        if (ram_rdata == key_r) begin
          status_nxt = ST_FOUND;
          index_nxt  = 16'(first_r);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    id_r     <= id_nxt;
    up_r     <= up_nxt;
    key_r    <= key_nxt;
    kv_r     <= kv_nxt;
    status_r <= status_nxt;
    index_r  <= index_nxt;
    first_r  <= first_nxt;
    len_r    <= len_nxt;
    mid_r    <= mid_nxt;
    i_r      <= i_nxt;
    pos_r    <= pos_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && in_ready))
    else $error("Input accepted while a result is pending.");

  a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FOUND)) |-> (32'(out_index) < 32'(used)))
    else $error("Found index lies outside the entries in use.");

  a_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((out_status == ST_NO_TABLE) || (out_status == ST_BAD_FMT)))
      |-> (!out_key_valid && (out_index == NOT_FOUND_IDX)))
    else $error("Rejected request reports a key or an index.");

  a_bin_window: assert property (@(posedge clk) disable iff (!rst_n)
    ((ctrl.op == OP_BTEST) || (ctrl.op == OP_BCMP))
      |-> ((32'(first_r) + 32'(len_r)) <= 32'(used)))
    else $error("Binary search window exceeds the entries in use.");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_LSCAN) |-> (i_r <= used))
    else $error("Linear scan pointer ran past the entries in use.");

endmodule

// ===== tb/tb_message_id_index_lookup.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_message_id_index_lookup
// Self-checking testbench for the message ID index lookup. The low end of
// the table is first filled with ascending IDs through load requests.
// Directed requests then cover every key format, the missing table, the
// all-ones key, duplicate entries, overflowing key parts and the count
// extremes. Random phases follow, each with its own register setting;
// those with a nonzero count up to FILL_DEPTH also load new table contents.
// A clocked driver and a clocked monitor apply random gaps and stalls on
// both sides, and one long output stall backs the block up. Every lookup
// answer is compared field by field against an independent prediction.
// ----------------------------------------------------------------------------
module tb_message_id_index_lookup
  import midx_pkg::*;
();

  localparam int         DEPTH        = TABLE_DEPTH_DEF;
  localparam int         FILL_DEPTH   = 40;
  localparam logic       MODE_LOAD    = 1'b0;
  localparam logic       MODE_LOOKUP  = 1'b1;
  localparam logic [2:0] FMT_ODD_LO   = 3'd5;
  localparam logic [2:0] FMT_ODD_HI   = 3'd7;
  localparam int         RANDOM_ITEMS = 490;
  localparam int         HOLD_CYCLES  = 400;
  localparam int         DRAIN_CYCLES = 40;
  localparam int         MAX_GAP      = 18;

  typedef struct packed {
    logic        mode;
    logic [9:0]  addr;
    logic [31:0] value;
    logic [31:0] id;
    logic [31:0] up;
  } request_t;

  typedef struct packed {
    logic [15:0] index;
    logic        key_valid;
    status_t     status;
  } answer_t;

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        cfg_valid      = 1'b0;
  wire         cfg_ready;
  logic [7:0]  cfg_addr       = '0;
  logic [31:0] cfg_data       = '0;
  logic        in_valid       = 1'b0;
  wire         in_ready;
  logic        in_mode        = MODE_LOAD;
  logic [9:0]  in_entry_addr  = '0;
  logic [31:0] in_entry_value = '0;
  logic [31:0] in_msg_id      = '0;
  logic [31:0] in_upper_half  = '0;
  wire         out_valid;
  logic        out_ready      = 1'b0;
  wire  [15:0] out_index;
  wire         out_key_valid;
  wire  [1:0]  out_status;

  message_id_index_lookup dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_entry_addr (in_entry_addr),
    .in_entry_value(in_entry_value),
    .in_msg_id     (in_msg_id),
    .in_upper_half (in_upper_half),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_index     (out_index),
    .out_key_valid (out_key_valid),
    .out_status    (out_status)
  );

  logic [31:0] table_img [DEPTH];
  logic [31:0] plan_mem  [DEPTH];
  logic        sh_present = 1'b0;
  logic [2:0]  sh_format  = FMT_ID;
  logic        sh_sorted  = 1'b0;
  logic [10:0] sh_count   = '0;

  request_t    pending_requests [$];
  answer_t     predicted_answers [$];
  request_t    cur_req;
  answer_t     exp_ans;

  int          gap_max      = MAX_GAP;
  int          gap_left     = 0;
  int          stall_left   = 0;
  logic        hold_arm     = 1'b0;
  logic        hold_done    = 1'b0;
  int          hold_cnt     = 0;
  wire         hold_active  = hold_arm && !hold_done;

  int          mismatch_cnt = 0;
  int          n_loads      = 0;
  int          n_lookups    = 0;
  int          n_checked    = 0;
  int          n_cfg        = 0;
  int          queued_items = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(40_000_000);
    $display("Timeout with %0d answers still outstanding.", predicted_answers.size());
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic answer_t resolve_lookup(logic [31:0] id, logic [31:0] up);
    answer_t     a;
    logic [31:0] key;
    logic        hit;
    int unsigned span;
    int unsigned lo;
    int unsigned len;
    int unsigned half;
    int unsigned mid;
    int unsigned pos;
    int unsigned i;
    a.index     = NOT_FOUND_IDX;
    a.key_valid = 1'b0;
    a.status    = ST_NO_TABLE;
    key         = '0;
    hit         = 1'b0;
    pos         = 0;
    if (!sh_present) begin
      return a;
    end
    case (sh_format)
      FMT_ID: begin
        key         = id;
        a.key_valid = (up == 32'd0);
      end
      FMT_ID24: begin
        key         = (id << 8) | (up & 32'h0000_00FF);
        a.key_valid = ((id >> 24) == 32'd0) && ((up >> 8) == 32'd0);
      end
      FMT_ID16: begin
        key         = (id << 16) | (up & 32'h0000_FFFF);
        a.key_valid = ((id >> 16) == 32'd0) && ((up >> 16) == 32'd0);
      end
      FMT_ID8: begin
        key         = (id << 24) | (up & 32'h00FF_FFFF);
        a.key_valid = ((id >> 8) == 32'd0) && ((up >> 24) == 32'd0);
      end
      FMT_UPPER: begin
        key         = up;
        a.key_valid = (id == 32'd0);
      end
      default: begin
        a.status = ST_BAD_FMT;
        return a;
      end
    endcase
    span = (sh_count > DEPTH) ? DEPTH : sh_count;
    if (key != ALL_ONES_KEY) begin
      if (sh_sorted) begin
        lo  = 0;
        len = span;
        while (len > 0) begin
          half = len >> 1;
          mid  = lo + half;
          if (table_img[mid] < key) begin
            lo  = mid + 1;
            len = len - half - 1;
          end else begin
            len = half;
          end
        end
        if (lo < span) begin
          hit = (table_img[lo] == key);
          pos = lo;
        end
      end else begin
        for (i = 0; i < span && !hit; i++) begin
          if (table_img[i] == key) begin
            hit = 1'b1;
            pos = i;
          end
        end
      end
    end
    if (hit) begin
      a.index  = pos[15:0];
      a.status = ST_FOUND;
    end else begin
      a.status = ST_MISS;
    end
    return a;
  endfunction

  function automatic logic [63:0] split_key(logic [2:0] fmt, logic [31:0] key, logic spoil);
    logic [31:0] junk;
    logic [31:0] id;
    logic [31:0] up;
    junk = spoil ? $urandom : 32'd0;
    case (fmt)
      FMT_ID: begin
        id = key;
        up = junk;
      end
      FMT_ID24: begin
        id = {junk[31:24], key[31:8]};
        up = {junk[23:0], key[7:0]};
      end
      FMT_ID16: begin
        id = {junk[31:16], key[31:16]};
        up = {junk[15:0], key[15:0]};
      end
      FMT_ID8: begin
        id = {junk[31:8], key[31:24]};
        up = {junk[7:0], key[23:0]};
      end
      FMT_UPPER: begin
        id = junk;
        up = key;
      end
      default: begin
        id = $urandom;
        up = $urandom;
      end
    endcase
    return {id, up};
  endfunction

  function automatic int draw_gap();
    if (gap_max == 0 || $urandom_range(0, 2) == 0) begin
      return 0;
    end
    return int'($urandom_range(0, gap_max));
  endfunction

  task automatic queue_load(input logic [9:0] addr, input logic [31:0] value);
    request_t rq;
    rq.mode  = MODE_LOAD;
    rq.addr  = addr;
    rq.value = value;
    rq.id    = $urandom;
    rq.up    = $urandom;
    plan_mem[addr] = value;
    pending_requests = {pending_requests, rq};
    queued_items++;
  endtask

  task automatic queue_lookup(input logic [31:0] id, input logic [31:0] up);
    request_t rq;
    rq.mode  = MODE_LOOKUP;
    rq.addr  = 10'($urandom_range(0, DEPTH - 1));
    rq.value = $urandom;
    rq.id    = id;
    rq.up    = up;
    pending_requests = {pending_requests, rq};
    queued_items++;
  endtask

  task automatic queue_key(input logic [31:0] key, input logic spoil);
    logic [63:0] parts;
    parts = split_key(sh_format, key, spoil);
    queue_lookup(parts[63:32], parts[31:0]);
  endtask

  task automatic settle();
    while ((n_loads + n_lookups) != queued_items || predicted_answers.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_addr  <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_TABLE_PRESENT: sh_present = val[0];
      REG_KEY_FORMAT:    sh_format  = val[2:0];
      REG_SORTED_TABLE:  sh_sorted  = val[0];
      REG_ENTRY_COUNT:   sh_count   = val[10:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic present, input logic [2:0] fmt, input logic sorted_sel,
                            input logic [10:0] cnt);
    settle();
    write_reg(REG_TABLE_PRESENT, {31'd0, present});
    write_reg(REG_KEY_FORMAT, {29'd0, fmt});
    write_reg(REG_SORTED_TABLE, {31'd0, sorted_sel});
    write_reg(REG_ENTRY_COUNT, {21'd0, cnt});
    n_cfg++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        if (cur_req.mode == MODE_LOAD) begin
          table_img[cur_req.addr] = cur_req.value;
          n_loads++;
        end else begin
          predicted_answers = {predicted_answers, resolve_lookup(cur_req.id, cur_req.up)};
          n_lookups++;
        end
        gap_left = draw_gap();
      end
      if (in_valid && !in_ready) begin
        in_valid <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        cur_req = pending_requests.pop_front();
        in_valid       <= 1'b1;
        in_mode        <= cur_req.mode;
        in_entry_addr  <= cur_req.addr;
        in_entry_value <= cur_req.value;
        in_msg_id      <= cur_req.id;
        in_upper_half  <= cur_req.up;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_arm && !hold_done) begin
      if (hold_cnt == HOLD_CYCLES - 1) begin
        hold_done <= 1'b1;
      end
      hold_cnt <= hold_cnt + 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_answers.size() == 0) begin
          $display("%0t: unexpected answer, expected none, actual index %h key_valid %b status %0d",
                   $time, out_index, out_key_valid, out_status);
          mismatch_cnt++;
        end else begin
          exp_ans = predicted_answers.pop_front();
          n_checked++;
          if (out_index !== exp_ans.index) begin
            $display("%0t: index expected %h, actual %h", $time, exp_ans.index, out_index);
            mismatch_cnt++;
          end
          if (out_key_valid !== exp_ans.key_valid) begin
            $display("%0t: key_valid expected %b, actual %b", $time, exp_ans.key_valid,
                     out_key_valid);
            mismatch_cnt++;
          end
          if (out_status !== exp_ans.status) begin
            $display("%0t: status expected %0d, actual %0d", $time, exp_ans.status, out_status);
            mismatch_cnt++;
          end
        end
        stall_left = draw_gap();
      end
      if (hold_active) begin
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned i;
    int unsigned r;
    int unsigned cnt;
    int unsigned span;
    int unsigned reach;
    int unsigned shape;
    int unsigned n;
    int unsigned a;
    int          rand_start;
    logic        wide;
    logic [2:0]  fmt;
    logic [31:0] acc;
    logic [31:0] pool_base;
    logic [31:0] pick;
    logic [31:0] key;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < FILL_DEPTH; i++) begin
      queue_load(10'(i), (i << 24) | $urandom_range(0, 32'h00FF_FFFF));
    end

    // A lookup before any table is supplied.
    queue_lookup(32'd0, 32'd0);

    set_config(1'b1, FMT_ID, 1'b0, 11'd8);
    queue_key(plan_mem[0], 1'b0);
    queue_key(plan_mem[7], 1'b0);
    queue_key(plan_mem[8], 1'b0);
    queue_key(plan_mem[1], 1'b1);
    queue_load(10'd5, plan_mem[2]);
    queue_key(plan_mem[2], 1'b0);
    queue_load(10'd3, ALL_ONES_KEY);
    queue_key(ALL_ONES_KEY, 1'b0);

    set_config(1'b1, FMT_ID24, 1'b0, 11'd8);
    queue_lookup(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_key(plan_mem[6], 1'b0);
    set_config(1'b1, FMT_ID16, 1'b0, 11'd8);
    queue_key(plan_mem[4], 1'b1);
    queue_lookup(32'd0, 32'd0);
    set_config(1'b1, FMT_ID8, 1'b1, 11'd8);
    queue_key(plan_mem[7], 1'b0);
    queue_key(plan_mem[2], 1'b1);
    set_config(1'b1, FMT_UPPER, 1'b0, 11'd8);
    queue_lookup(32'd0, plan_mem[0]);
    queue_lookup(32'hFFFF_FFFF, plan_mem[1]);
    set_config(1'b1, FMT_ODD_LO, 1'b0, 11'd8);
    queue_lookup($urandom, $urandom);
    set_config(1'b1, FMT_ODD_HI, 1'b1, 11'd8);
    queue_lookup($urandom, $urandom);

    set_config(1'b1, FMT_ID, 1'b1, 11'd0);
    queue_key(plan_mem[0], 1'b0);
    set_config(1'b1, FMT_ID, 1'b1, 11'(FILL_DEPTH));
    queue_key(plan_mem[FILL_DEPTH - 1], 1'b0);
    queue_key(plan_mem[20], 1'b0);
    queue_key(plan_mem[13] + 32'd1, 1'b0);
    set_config(1'b1, FMT_ID, 1'b0, 11'(DEPTH));
    queue_key(plan_mem[FILL_DEPTH - 1], 1'b0);
    set_config(1'b1, FMT_ID, 1'b0, 11'h7FF);
    queue_key(plan_mem[30], 1'b0);

    // Hold the output off while lookups keep arriving back to back.
    set_config(1'b1, FMT_ID, 1'b0, 11'd16);
    gap_max  <= 0;
    hold_arm <= 1'b1;
    repeat (14) queue_key(plan_mem[$urandom_range(0, 15)], 1'b0);
    settle();
    gap_max <= MAX_GAP;

    rand_start = queued_items;
    while (queued_items < rand_start + RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        cnt = DEPTH;
      end else if (r < 15) begin
        cnt = $urandom_range(DEPTH + 1, 2047);
      end else if (r < 20) begin
        cnt = 0;
      end else if (r < 25) begin
        cnt = 1;
      end else begin
        cnt = $urandom_range(2, 40);
      end
      if ($urandom_range(0, 9) == 0) begin
        fmt = 3'($urandom_range(FMT_ODD_LO, FMT_ODD_HI));
      end else begin
        fmt = 3'($urandom_range(FMT_ID, FMT_UPPER));
      end
      span  = (cnt > DEPTH) ? DEPTH : cnt;
      wide  = (span > FILL_DEPTH);
      reach = wide ? FILL_DEPTH : span;
      set_config(($urandom_range(0, 11) != 0), fmt,
                 wide ? 1'b0 : 1'($urandom_range(0, 1)), 11'(cnt));
      gap_max <= ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;

      if (span > 0 && !wide) begin
        shape     = $urandom_range(0, 3);
        acc       = $urandom_range(0, 32'h3FFF_FFFF);
        pool_base = $urandom;
        for (i = 0; i < span; i++) begin
          if (shape < 2) begin
            queue_load(10'(i), acc);
            acc = acc + $urandom_range(1, 32'h03FF_FFFF);
          end else if (shape == 2) begin
            queue_load(10'(i), pool_base + $urandom_range(0, 5));
          end else begin
            queue_load(10'(i), $urandom);
          end
        end
      end

      n = $urandom_range(8, 30);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          if (reach > 0 && $urandom_range(0, 2) != 0) begin
            a = $urandom_range(0, reach - 1);
          end else begin
            a = $urandom_range(0, DEPTH - 1);
          end
          if ($urandom_range(0, 1) == 1) begin
            queue_load(10'(a), plan_mem[$urandom_range(0, FILL_DEPTH - 1)]);
          end else begin
            queue_load(10'(a), $urandom);
          end
        end else if (r >= 92 && !wide) begin
          queue_lookup($urandom, $urandom);
        end else begin
          pick = (reach > 0) ? plan_mem[$urandom_range(0, reach - 1)] : $urandom;
          if (r < 60) begin
            key = pick;
          end else if (r < 72) begin
            key = ($urandom_range(0, 1) == 1) ? pick + 32'd1 : pick - 32'd1;
          end else if (r < 80) begin
            key = ALL_ONES_KEY;
          end else begin
            key = $urandom;
          end
          // Over a large count only keys that stop early on a written entry are used.
          if (wide && key != ALL_ONES_KEY) begin
            key = pick;
          end
          queue_key(key, ($urandom_range(0, 3) == 0));
        end
      end
    end

    settle();
    $display("Checked %0d answers from %0d lookups alongside %0d table loads.",
             n_checked, n_lookups, n_loads);
    $display("Ran %0d register settings with all key formats, counts 0 to 2047 and a long stall.",
             n_cfg);
    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/midx_pkg.sv
design/midx_ram.sv
design/midx_seq.sv
design/message_id_index_lookup.sv
tb/tb_message_id_index_lookup.sv
